// ===== hw/rtl/circular_fifo_with_search_defines.svh =====
// ----------------------------------------------------------------------------
// circular_fifo_with_search assertion macros
// shared property wrappers used by the top level checks
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_WITH_SEARCH_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_DEFINES_SVH

// condition holds at every clock edge outside reset
`define CFWS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("cfws check failed");

// antecedent implies consequent in the same cycle
`define CFWS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfws check failed");

// antecedent implies consequent in the next cycle
`define CFWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfws check failed");

`endif

// ===== hw/rtl/cfws_pkg.sv =====
// ----------------------------------------------------------------------------
// cfws_pkg
// shared constants, types and helpers of the searchable circular fifo
// ----------------------------------------------------------------------------
package cfws_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int MODE_W     = 2;
   localparam int STAT_W     = 2;
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // request mode codes
   localparam logic [MODE_W-1:0] MODE_ENQ    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQ    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      OP_ENQ,
      OP_DEQ,
      OP_SEARCH,
      OP_NOP
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEQ,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [DATA_WIDTH-1:0]  value;
   } cmd_type;

   localparam int RSP_FIELD_W = STAT_W + 1 + SLOT_W + 2 * DATA_WIDTH + CNT_W + 2;
   localparam int RSP_BITS    = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef struct packed {
      logic [RSP_BITS-RSP_FIELD_W-1:0] pad;
      logic                            is_full;
      logic                            is_empty;
      logic [CNT_W-1:0]                occupancy;
      logic [DATA_WIDTH-1:0]           rear_value;
      logic [DATA_WIDTH-1:0]           front_value;
      logic [SLOT_W-1:0]               found_slot;
      logic                            found;
      logic [STAT_W-1:0]               status;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] occupancy;
      logic [CNT_W-1:0] capacity;
   } mon_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0]  cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(s) + CNT_W'(1);
      return (n >= cap) ? '0 : n[SLOT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/cfws_front.sv =====
// ----------------------------------------------------------------------------
// cfws_front
// accepts request transactions, decodes the mode and queues commands
// ----------------------------------------------------------------------------
module cfws_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cfws_pkg::DATA_WIDTH-1:0]  req_tdata,  // item_value
   input  logic [cfws_pkg::MODE_W-1:0]      req_tuser,  // mode
   output logic                             cmd_valid,
   input  logic                             cmd_pop,
   output cfws_pkg::cmd_type                cmd
);
   import cfws_pkg::*;

   cmd_type               slot_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   cmd_type               dec_cmd;
   logic                  push;
   logic                  pop;

   always_comb begin
      unique case (req_tuser)
         MODE_ENQ:    dec_cmd.op = OP_ENQ;
         MODE_DEQ:    dec_cmd.op = OP_DEQ;
         MODE_SEARCH: dec_cmd.op = OP_SEARCH;
         default:     dec_cmd.op = OP_NOP;
      endcase
      dec_cmd.value = req_tdata;
   end

   assign req_tready = (cnt_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != '0);
   assign pop        = cmd_pop && cmd_valid;
   assign cmd        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + CMDQ_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + CMDQ_PTR_W'(1);
      end
      priority if (push && !pop) begin
         cnt_in = cnt_ff + CMDQ_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CMDQ_CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec_cmd;
      end
   end

endmodule

// ===== hw/rtl/cfws_back.sv =====
// ----------------------------------------------------------------------------
// cfws_back
// executes queued commands on the ring buffer and drives the response register
// ----------------------------------------------------------------------------
module cfws_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_pop,
   input  cfws_pkg::cmd_type                cmd,
   input  logic                             csr_we,
   input  logic [cfws_pkg::CNT_W-1:0]       csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cfws_pkg::RSP_BITS-1:0]    rsp_tdata,
   output cfws_pkg::mon_type                mon
);
   import cfws_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     head_ff, head_in;
   logic [SLOT_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      cap_ff, cap_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] rear_ff, rear_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [SLOT_W-1:0]     scan_ff, scan_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic                  found_ff, found_in;
   logic [SLOT_W-1:0]     fslot_ff, fslot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff;

   logic                  out_free;
   logic                  emit;
   logic [STAT_W-1:0]     res_status;
   logic                  res_found;
   logic [SLOT_W-1:0]     res_slot;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   logic                  rd_en;
   logic [SLOT_W-1:0]     rd_addr;
   logic [CNT_W-1:0]      cap_sat;
   rsp_type               rsp_next;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cap_sat  = (csr_wdata == '0 || csr_wdata > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                                   : csr_wdata;

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      cap_in     = cap_ff;
      front_in   = front_ff;
      rear_in    = rear_ff;
      key_in     = key_ff;
      scan_in    = scan_ff;
      left_in    = left_ff;
      found_in   = found_ff;
      fslot_in   = fslot_ff;
      cmd_pop    = 1'b0;
      emit       = 1'b0;
      res_status = STAT_DONE;
      res_found  = 1'b0;
      res_slot   = '0;
      mem_we     = 1'b0;
      mem_waddr  = next_slot(tail_ff, cap_ff);
      rd_en      = 1'b0;
      rd_addr    = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.op)
                  OP_ENQ: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                        if (count_ff >= cap_ff) begin
                           res_status = STAT_FULL;
                        end else begin
                           tail_in  = mem_waddr;
                           mem_we   = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                           rear_in  = cmd.value;
                           if (count_ff == '0) begin
                              front_in = cmd.value;
                           end
                        end
                     end
                  end
                  OP_DEQ: begin
                     if (count_ff == '0) begin
                        if (out_free) begin
                           cmd_pop    = 1'b1;
                           emit       = 1'b1;
                           res_status = STAT_EMPTY;
                        end
                     end else begin
                        // fetch the new oldest entry for the front value
                        cmd_pop  = 1'b1;
                        head_in  = next_slot(head_ff, cap_ff);
                        count_in = count_ff - CNT_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = head_in;
                        state_in = ST_DEQ;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        if (out_free) begin
                           cmd_pop    = 1'b1;
                           emit       = 1'b1;
                           res_status = STAT_EMPTY;
                        end
                     end else begin
                        cmd_pop  = 1'b1;
                        key_in   = cmd.value;
                        scan_in  = head_ff;
                        left_in  = count_ff;
                        found_in = 1'b0;
                        fslot_in = '0;
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_NOP: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_DEQ: begin
            front_in = rd_data_ff;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // one stored entry compared per cycle, oldest first
            if (rd_data_ff == key_ff) begin
               found_in = 1'b1;
               fslot_in = scan_ff;
               state_in = ST_FIN;
            end else if (left_ff == CNT_W'(1)) begin
               state_in = ST_FIN;
            end else begin
               scan_in = next_slot(scan_ff, cap_ff);
               left_in = left_ff - CNT_W'(1);
               rd_en   = 1'b1;
               rd_addr = scan_in;
            end
         end
         ST_FIN: begin
            res_found = found_ff;
            res_slot  = fslot_ff;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase

      // capacity change only takes effect on an empty fifo
      if (csr_we && count_ff == '0) begin
         cap_in  = cap_sat;
         head_in = '0;
         tail_in = SLOT_W'(cap_sat - CNT_W'(1));
      end
   end

   always_comb begin
      rsp_next.pad         = '0;
      rsp_next.status      = res_status;
      rsp_next.found       = res_found;
      rsp_next.found_slot  = res_slot;
      rsp_next.front_value = (count_in == '0) ? '0 : front_in;
      rsp_next.rear_value  = (count_in == '0) ? '0 : rear_in;
      rsp_next.occupancy   = count_in;
      rsp_next.is_empty    = (count_in == '0);
      rsp_next.is_full     = (count_in == cap_ff);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= SLOT_W'(DEPTH - 1);
         count_ff     <= '0;
         cap_ff       <= CNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      rear_ff  <= rear_in;
      key_ff   <= key_in;
      scan_ff  <= scan_in;
      left_ff  <= left_in;
      found_ff <= found_in;
      fslot_ff <= fslot_in;
      if (emit) begin
         rsp_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_ff;
   assign mon.occupancy = count_ff;
   assign mon.capacity  = cap_ff;

endmodule

// ===== hw/rtl/circular_fifo_with_search.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// A ring-buffer fifo of 64 unsigned 32-bit words with a writable capacity and a
// value search. Requests enter a two-entry command queue and are executed by a
// back end that owns a single-port-write, single-port-read storage array and a
// registered response stage. Enqueue, rejected operations and unused modes
// respond straight from idle; a dequeue first does a registered read of the new
// oldest entry for the front value, then responds; a search compares stored
// entries up to and including the first match (all of them when none matches),
// one entry per cycle through the storage read port, then responds. Write the
// capacity only while the fifo is empty and idle; a value of 0 or above 64
// selects 64.
// ----------------------------------------------------------------------------
`include "circular_fifo_with_search_defines.svh"

module circular_fifo_with_search (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cfws_pkg::DATA_WIDTH-1:0]  req_tdata,  // item_value
   input  logic [cfws_pkg::MODE_W-1:0]      req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, found, found_slot, front_value, rear_value, occupancy,
   // is_empty, is_full, zero pad
   output logic [cfws_pkg::RSP_BITS-1:0]    rsp_tdata,
   input  logic                             csr_we,
   input  logic [cfws_pkg::CNT_W-1:0]       csr_wdata
);
   import cfws_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   mon_type mon;
   rsp_type rsp_view;
   logic    rsp_vals_zero;
   logic    rsp_found_legal;
   logic    cap_legal;

   cfws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd)
   );

   cfws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mon        (mon)
   );

   assign rsp_view        = rsp_type'(rsp_tdata);
   assign rsp_vals_zero   = (rsp_view.front_value == '0) && (rsp_view.rear_value == '0);
   assign rsp_found_legal = (rsp_view.status == STAT_DONE) && !rsp_view.is_empty;
   assign cap_legal       = (mon.capacity != '0) && (mon.capacity <= CNT_W'(DEPTH));

   `CFWS_ASSERT_ALWAYS(a_occ_le_cap, clock, reset, mon.occupancy <= mon.capacity)
   `CFWS_ASSERT_NEXT(a_cap_range, clock, reset, csr_we, cap_legal)
   `CFWS_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_tvalid && rsp_view.is_empty, rsp_vals_zero)
   `CFWS_ASSERT_IMPLY(a_found_ok, clock, reset, rsp_tvalid && rsp_view.found, rsp_found_legal)

endmodule
